// ===== src/mrtu_pkg.sv =====
// Shared types, constants and CRC helper for the Modbus RTU master frame engine.
`timescale 1ns / 1ps
package mrtu_pkg;

  localparam int RxDepthDef     = 64;
  localparam int MaxReadRegsDef = 16;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [7:0]  FnWrite = 8'h06;
  localparam logic [7:0]  FnRead  = 8'h03;

  localparam logic [1:0] OpWrite  = 2'd0;
  localparam logic [1:0] OpRead   = 2'd1;
  localparam logic [1:0] OpRxByte = 2'd2;
  localparam logic [1:0] OpEnd    = 2'd3;

  localparam logic [1:0] KindTx     = 2'd0;
  localparam logic [1:0] KindReg    = 2'd1;
  localparam logic [1:0] KindStatus = 2'd2;

  localparam logic [1:0] PhIdle  = 2'd0;
  localparam logic [1:0] PhWrite = 2'd1;
  localparam logic [1:0] PhRead  = 2'd2;

  localparam logic [3:0] StOk       = 4'd0;
  localparam logic [3:0] StNoReply  = 4'd1;
  localparam logic [3:0] StOverflow = 4'd2;
  localparam logic [3:0] StBadLen   = 4'd3;
  localparam logic [3:0] StBadCrc   = 4'd4;
  localparam logic [3:0] StBadSlave = 4'd5;
  localparam logic [3:0] StBadFn    = 4'd6;
  localparam logic [3:0] StBadEcho  = 4'd7;
  localparam logic [3:0] StBadReq   = 4'd8;

  typedef struct packed {
    logic       acc;
    logic       idx_clr;
    logic       idx_inc;
    logic       rd_hi;
    logic       rd_lo;
    logic       out_load;
    logic [1:0] out_kind;
    logic       out_last;
  } cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       phase_idle;
    logic       req_bad;
    logic       read_ok;
    logic       idx_tx_end;
    logic       idx_reg_end;
    logic       out_free;
  } sts_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    r = c ^ {8'h00, d};
    for (int b = 0; b < 8; b++) begin
      r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    end
    return r;
  endfunction

endpackage

// ===== src/mrtu_ctrl.sv =====
// Sequencing state machine: accepts items and steps the datapath through each result.
`timescale 1ns / 1ps
module mrtu_ctrl import mrtu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] STx   = 3'd1;
  localparam logic [2:0] SVHi  = 3'd2;
  localparam logic [2:0] SVLo  = 3'd3;
  localparam logic [2:0] SVOut = 3'd4;
  localparam logic [2:0] SStat = 3'd5;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != SIdle);
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.acc = 1'b1;
          case (sts_i.opcode)
            OpWrite, OpRead: begin
              if (sts_i.opcode == OpRead && sts_i.req_bad) begin
                state_d = SStat;
              end else begin
                cmd_o.idx_clr = 1'b1;
                state_d       = STx;
              end
            end
            OpEnd: begin
              if (!sts_i.phase_idle && sts_i.read_ok) begin
                cmd_o.idx_clr = 1'b1;
                state_d       = SVHi;
              end else begin
                state_d = SStat;
              end
            end
            default: state_d = SIdle;
          endcase
        end
      end
      STx: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = KindTx;
          cmd_o.out_last = sts_i.idx_tx_end;
          if (sts_i.idx_tx_end) begin
            state_d = SIdle;
          end else begin
            cmd_o.idx_inc = 1'b1;
          end
        end
      end
      SVHi: begin
        cmd_o.rd_hi = 1'b1;
        state_d     = SVLo;
      end
      SVLo: begin
        cmd_o.rd_lo = 1'b1;
        state_d     = SVOut;
      end
      SVOut: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = KindReg;
          if (sts_i.idx_reg_end) begin
            state_d = SStat;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = SVHi;
          end
        end
      end
      SStat: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = KindStatus;
          cmd_o.out_last = 1'b1;
          state_d        = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

endmodule

// ===== src/mrtu_dp.sv =====
// Datapath: request registers, receive buffer, CRC, reply checks and output register.
`timescale 1ns / 1ps
module mrtu_dp import mrtu_pkg::*; #(
  parameter int RX_DEPTH      = RxDepthDef,
  parameter int MAX_READ_REGS = MaxReadRegsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  slave_addr_i,
  input  logic [15:0] reg_addr_i,
  input  logic [15:0] value_i,
  input  logic [7:0]  rx_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  tx_data_o,
  output logic [3:0]  reg_index_o,
  output logic [15:0] reg_value_o,
  output logic [3:0]  status_o,
  output logic        last_o
);

  localparam int AW   = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int CW   = $clog2(RX_DEPTH + 1);
  localparam int IdxW = ($clog2(MAX_READ_REGS + 1) > 4) ? $clog2(MAX_READ_REGS + 1) : 4;
  localparam int SumW = AW + IdxW + 2;

  // control state
  logic [1:0]    phase_q;
  logic [7:0]    req_slave_q;
  logic [15:0]   req_reg_q;
  logic [15:0]   req_value_q;
  logic          req_rd_q;
  logic [CW-1:0] count_q;
  logic          ovf_q;
  logic [IdxW-1:0] idx_q;
  logic [3:0]    st_q;
  logic          out_valid_q;

  // payload
  logic [7:0]  mem_q [RX_DEPTH];
  logic [7:0]  rd_q, hi_q;
  logic [7:0]  b_q [6];
  logic [7:0]  last1_q, last2_q;
  logic [15:0] c0_q, c1_q, c2_q, tx_crc_q;
  logic [1:0]  kind_q;
  logic [7:0]  tx_q;
  logic [3:0]  ridx_q;
  logic [15:0] rval_q;
  logic [3:0]  stat_q;
  logic        last_q;

  logic          req_bad;
  logic          rx_wr;
  logic          out_free;
  logic [3:0]    chk;
  logic [17:0]   expect_len;
  logic [SumW-1:0] addr_hi, addr_lo;
  logic [7:0]    tx_byte;

  assign req_bad  = (value_i == 16'd0) || (value_i > 16'(MAX_READ_REGS));
  assign rx_wr    = cmd_i.acc && (opcode_i == OpRxByte) && (phase_q != PhIdle)
                    && (count_q != CW'(RX_DEPTH));
  assign out_free = !out_valid_q || !out_stall_i;

  assign expect_len = (phase_q == PhRead) ? (18'd5 + {1'b0, req_value_q, 1'b0}) : 18'd8;

  always_comb begin
    if (ovf_q) begin
      chk = StOverflow;
    end else if (count_q == '0) begin
      chk = StNoReply;
    end else if (18'(count_q) != expect_len) begin
      chk = StBadLen;
    end else if ({last1_q, last2_q} != c2_q) begin
      chk = StBadCrc;
    end else if (b_q[0] != req_slave_q) begin
      chk = StBadSlave;
    end else if (b_q[1] != ((phase_q == PhRead) ? FnRead : FnWrite)) begin
      chk = StBadFn;
    end else if (phase_q == PhRead) begin
      chk = (17'(b_q[2]) != {req_value_q, 1'b0}) ? StBadEcho : StOk;
    end else if (b_q[2] != req_reg_q[15:8] || b_q[3] != req_reg_q[7:0] ||
                 b_q[4] != req_value_q[15:8] || b_q[5] != req_value_q[7:0]) begin
      chk = StBadEcho;
    end else begin
      chk = StOk;
    end
  end

  always_comb begin
    sts_o             = '0;
    sts_o.opcode      = opcode_i;
    sts_o.phase_idle  = (phase_q == PhIdle);
    sts_o.req_bad     = req_bad;
    sts_o.read_ok     = (phase_q == PhRead) && (chk == StOk);
    sts_o.idx_tx_end  = (idx_q == IdxW'(7));
    sts_o.idx_reg_end = (17'(idx_q) + 17'd1) == 17'(req_value_q);
    sts_o.out_free    = out_free;
  end

  assign addr_hi = SumW'(3) + SumW'({idx_q, 1'b0});
  assign addr_lo = addr_hi + SumW'(1);

  always_comb begin
    case (idx_q[2:0])
      3'd0:    tx_byte = req_slave_q;
      3'd1:    tx_byte = req_rd_q ? FnRead : FnWrite;
      3'd2:    tx_byte = req_reg_q[15:8];
      3'd3:    tx_byte = req_reg_q[7:0];
      3'd4:    tx_byte = req_value_q[15:8];
      3'd5:    tx_byte = req_value_q[7:0];
      3'd6:    tx_byte = tx_crc_q[7:0];
      default: tx_byte = tx_crc_q[15:8];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      req_slave_q <= '0;
      req_reg_q   <= '0;
      req_value_q <= '0;
      req_rd_q    <= 1'b0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      idx_q       <= '0;
      st_q        <= StOk;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.acc) begin
        case (opcode_i)
          OpWrite, OpRead: begin
            count_q <= '0;
            ovf_q   <= 1'b0;
            if (opcode_i == OpRead && req_bad) begin
              phase_q <= PhIdle;
              st_q    <= StBadReq;
            end else begin
              req_slave_q <= slave_addr_i;
              req_reg_q   <= reg_addr_i;
              req_value_q <= value_i;
              req_rd_q    <= (opcode_i == OpRead);
              if (opcode_i == OpRead) begin
                phase_q <= PhRead;
              end else begin
                phase_q <= (slave_addr_i == 8'd0) ? PhIdle : PhWrite;
              end
            end
          end
          OpRxByte: begin
            if (rx_wr) begin
              count_q <= count_q + CW'(1);
            end else if (phase_q != PhIdle) begin
              ovf_q <= 1'b1;
            end
          end
          default: begin
            st_q    <= (phase_q == PhIdle) ? StBadReq : chk;
            phase_q <= PhIdle;
            count_q <= '0;
            ovf_q   <= 1'b0;
          end
        endcase
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + IdxW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // receive buffer, running CRC history and frame bytes
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc && (opcode_i == OpWrite || opcode_i == OpRead || opcode_i == OpEnd)) begin
      c0_q     <= CrcInit;
      tx_crc_q <= CrcInit;
    end
    if (rx_wr) begin
      mem_q[count_q[AW-1:0]] <= rx_data_i;
      c0_q    <= crc_byte(c0_q, rx_data_i);
      c1_q    <= c0_q;
      c2_q    <= c1_q;
      last1_q <= rx_data_i;
      last2_q <= last1_q;
      for (int i = 0; i < 6; i++) begin
        if (count_q == CW'(i)) begin
          b_q[i] <= rx_data_i;
        end
      end
    end
    if (cmd_i.rd_hi) begin
      rd_q <= mem_q[addr_hi[AW-1:0]];
    end
    if (cmd_i.rd_lo) begin
      hi_q <= rd_q;
      rd_q <= mem_q[addr_lo[AW-1:0]];
    end
    if (cmd_i.out_load) begin
      kind_q <= cmd_i.out_kind;
      last_q <= cmd_i.out_last;
      tx_q   <= '0;
      ridx_q <= '0;
      rval_q <= '0;
      stat_q <= '0;
      case (cmd_i.out_kind)
        KindTx: begin
          tx_q <= tx_byte;
          if (idx_q < IdxW'(6)) begin
            tx_crc_q <= crc_byte(tx_crc_q, tx_byte);
          end
        end
        KindReg: begin
          ridx_q <= idx_q[3:0];
          rval_q <= {hi_q, rd_q};
        end
        default: stat_q <= st_q;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign tx_data_o   = tx_q;
  assign reg_index_o = ridx_q;
  assign reg_value_o = rval_q;
  assign status_o    = stat_q;
  assign last_o      = last_q;

endmodule

// ===== src/modbus_rtu_master_frame_engine_top.sv =====
// Top level of the Modbus RTU master frame engine.
`timescale 1ns / 1ps
// Usage:
//  Input channel (in_valid_i / in_stall_o) carries one command per transfer:
//  start write-single, start read-holding, received byte, or frame end.
//  Output channel (out_valid_o / out_stall_i) carries results: transmit
//  bytes, register values and status; last_o marks the final result of a command.
// Timing:
//  A received byte produces no result.
//  A request is accepted, then gives one transmit byte per cycle while the
//  output does not stall (8 in all); a rejected read count gives one status.
//  A frame end is checked in the accept cycle from registered byte and CRC
//  history; a good read reply then streams values, each read in states SVHi
//  and SVLo over the single registered read port of the receive buffer, then status.
//  One command is in flight at a time; the next is taken once its last
//  result sits in the output register.
// Reset clears phase, counts and output valid; the buffer needs no clearing.
// A stall on the output holds the result register and pauses the sequencer.
module modbus_rtu_master_frame_engine_top import mrtu_pkg::*; #(
  parameter int RX_DEPTH      = RxDepthDef,
  parameter int MAX_READ_REGS = MaxReadRegsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  slave_addr_i,
  input  logic [15:0] reg_addr_i,
  input  logic [15:0] value_i,
  input  logic [7:0]  rx_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  tx_data_o,
  output logic [3:0]  reg_index_o,
  output logic [15:0] reg_value_o,
  output logic [3:0]  status_o,
  output logic        last_o
);

  cmd_t cmd;
  sts_t sts;

  mrtu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mrtu_dp #(
    .RX_DEPTH      (RX_DEPTH),
    .MAX_READ_REGS (MAX_READ_REGS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .opcode_i     (opcode_i),
    .slave_addr_i (slave_addr_i),
    .reg_addr_i   (reg_addr_i),
    .value_i      (value_i),
    .rx_data_i    (rx_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .tx_data_o    (tx_data_o),
    .reg_index_o  (reg_index_o),
    .reg_value_o  (reg_value_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

endmodule

// ===== sim/modbus_rtu_master_frame_engine_checker.sv =====
// Result checker for the Modbus RTU master frame engine: predicts and compares results.
`timescale 1ns / 1ps
module modbus_rtu_master_frame_engine_checker import mrtu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  slave_addr_i,
  input  logic [15:0] reg_addr_i,
  input  logic [15:0] value_i,
  input  logic [7:0]  rx_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  tx_data_i,
  input  logic [3:0]  reg_index_i,
  input  logic [15:0] reg_value_i,
  input  logic [3:0]  status_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_data;
    logic [3:0]  reg_index;
    logic [15:0] reg_value;
    logic [3:0]  status;
    logic        last;
  } frame_result_t;

  frame_result_t expected_results[$];

  logic [1:0]  mdl_phase;
  logic [7:0]  mdl_slave;
  logic [15:0] mdl_reg;
  logic [15:0] mdl_value;
  logic [7:0]  mdl_rx_buf[RxDepthDef];
  int          mdl_rx_count;
  logic        mdl_overflow;

  assign pending_o = expected_results.size();

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count_o++;
  endtask

  task automatic push_result(input logic [1:0] k, input logic [7:0] tx, input logic [3:0] idx,
                             input logic [15:0] val, input logic [3:0] st);
    frame_result_t r;
    r = '{kind: k, tx_data: tx, reg_index: idx, reg_value: val, status: st, last: 1'b0};
    expected_results.push_back(r);
  endtask

  function automatic logic [15:0] rx_crc(input int n);
    logic [15:0] c;
    c = 16'hFFFF;
    for (int i = 0; i < n; i++) begin
      c = c ^ {8'h00, mdl_rx_buf[i]};
      for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [3:0] reply_status();
    int          want_len;
    logic [15:0] got;
    logic [7:0]  fn;
    fn = (mdl_phase == PhRead) ? FnRead : FnWrite;
    if (mdl_overflow) return StOverflow;
    if (mdl_rx_count == 0) return StNoReply;
    want_len = (mdl_phase == PhRead) ? 5 + 2 * mdl_value : 8;
    if (mdl_rx_count != want_len) return StBadLen;
    got = {mdl_rx_buf[want_len - 1], mdl_rx_buf[want_len - 2]};
    if (got != rx_crc(want_len - 2)) return StBadCrc;
    if (mdl_rx_buf[0] != mdl_slave) return StBadSlave;
    if (mdl_rx_buf[1] != fn) return StBadFn;
    if (mdl_phase == PhRead) begin
      if (mdl_rx_buf[2] != 8'(2 * mdl_value)) return StBadEcho;
    end else if ({mdl_rx_buf[2], mdl_rx_buf[3]} != mdl_reg ||
                 {mdl_rx_buf[4], mdl_rx_buf[5]} != mdl_value) begin
      return StBadEcho;
    end
    return StOk;
  endfunction

  // Apply one accepted command to the predictor and queue what it causes.
  task automatic predict_frame_results(input logic [1:0] op, input logic [7:0] sa,
                                       input logic [15:0] ra, input logic [15:0] va,
                                       input logic [7:0] rd);
    int          n_prior;
    logic [7:0]  f[8];
    logic [15:0] c;
    logic [3:0]  st;
    n_prior = expected_results.size();
    if (op == OpWrite || op == OpRead) begin
      mdl_rx_count = 0;
      mdl_overflow = 1'b0;
      if (op == OpRead && (va == 0 || va > MaxReadRegsDef)) begin
        mdl_phase = PhIdle;
        push_result(KindStatus, 0, 0, 0, StBadReq);
      end else begin
        mdl_slave = sa;
        mdl_reg   = ra;
        mdl_value = va;
        f[0] = sa;
        f[1] = (op == OpRead) ? FnRead : FnWrite;
        f[2] = ra[15:8];
        f[3] = ra[7:0];
        f[4] = va[15:8];
        f[5] = va[7:0];
        c = 16'hFFFF;
        for (int i = 0; i < 6; i++) begin
          c = c ^ {8'h00, f[i]};
          for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        end
        f[6] = c[7:0];
        f[7] = c[15:8];
        for (int i = 0; i < 8; i++) push_result(KindTx, f[i], 0, 0, StOk);
        if (op == OpRead) mdl_phase = PhRead;
        else mdl_phase = (sa == 0) ? PhIdle : PhWrite;
      end
    end else if (op == OpRxByte) begin
      if (mdl_phase != PhIdle) begin
        if (mdl_rx_count < RxDepthDef) begin
          mdl_rx_buf[mdl_rx_count] = rd;
          mdl_rx_count++;
        end else begin
          mdl_overflow = 1'b1;
        end
      end
    end else begin
      if (mdl_phase == PhIdle) begin
        push_result(KindStatus, 0, 0, 0, StBadReq);
      end else begin
        st = reply_status();
        if (st == StOk && mdl_phase == PhRead)
          for (int i = 0; i < mdl_value; i++)
            push_result(KindReg, 0, 4'(i), {mdl_rx_buf[3 + 2 * i], mdl_rx_buf[4 + 2 * i]},
                        StOk);
        push_result(KindStatus, 0, 0, 0, st);
      end
      mdl_phase    = PhIdle;
      mdl_rx_count = 0;
      mdl_overflow = 1'b0;
    end
    if (expected_results.size() > n_prior) expected_results[$].last = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_result_t exp_r;
    if (!rst_ni) begin
      mdl_phase    <= PhIdle;
      mdl_slave    <= '0;
      mdl_reg      <= '0;
      mdl_value    <= '0;
      mdl_rx_count <= 0;
      mdl_overflow <= 1'b0;
      fail_count_o <= 0;
      expected_results.delete();
    end else begin
      // Check output first; a command can only produce results in a later cycle.
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          exp_r = expected_results.pop_front();
          if (kind_i !== exp_r.kind)
            report_mismatch($sformatf("kind %0d exp %0d", kind_i, exp_r.kind));
          if (tx_data_i !== exp_r.tx_data)
            report_mismatch($sformatf("tx_data %h exp %h", tx_data_i, exp_r.tx_data));
          if (reg_index_i !== exp_r.reg_index)
            report_mismatch($sformatf("reg_index %0d exp %0d", reg_index_i, exp_r.reg_index));
          if (reg_value_i !== exp_r.reg_value)
            report_mismatch($sformatf("reg_value %h exp %h", reg_value_i, exp_r.reg_value));
          if (status_i !== exp_r.status)
            report_mismatch($sformatf("status %0d exp %0d", status_i, exp_r.status));
          if (last_i !== exp_r.last)
            report_mismatch($sformatf("last %b exp %b", last_i, exp_r.last));
        end
      end
      if (in_valid_i && !in_stall_i)
        predict_frame_results(opcode_i, slave_addr_i, reg_addr_i, value_i, rx_data_i);
    end
  end

endmodule

// ===== sim/modbus_rtu_master_frame_engine_top_tb.sv =====
// Stimulus and verdict for the Modbus RTU master frame engine testbench.
`timescale 1ns / 1ps
module modbus_rtu_master_frame_engine_top_tb import mrtu_pkg::*;;

  localparam int CycleLimit = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  opcode;
  logic [7:0]  slave_addr;
  logic [15:0] reg_addr;
  logic [15:0] value;
  logic [7:0]  rx_data;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  tx_data;
  logic [3:0]  reg_index;
  logic [15:0] reg_value;
  logic [3:0]  status;
  logic        last;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  int          send_idle_pct;
  int          recv_stall_pct;

  // Reply-building state: the last request issued, so replies can echo it.
  logic [7:0]  cur_slave;
  logic [15:0] cur_reg;
  logic [15:0] cur_value;
  logic        cur_is_read;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  modbus_rtu_master_frame_engine_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .opcode_i    (opcode),
    .slave_addr_i(slave_addr),
    .reg_addr_i  (reg_addr),
    .value_i     (value),
    .rx_data_i   (rx_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .kind_o      (kind),
    .tx_data_o   (tx_data),
    .reg_index_o (reg_index),
    .reg_value_o (reg_value),
    .status_o    (status),
    .last_o      (last)
  );

  modbus_rtu_master_frame_engine_checker checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .opcode_i    (opcode),
    .slave_addr_i(slave_addr),
    .reg_addr_i  (reg_addr),
    .value_i     (value),
    .rx_data_i   (rx_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .kind_i      (kind),
    .tx_data_i   (tx_data),
    .reg_index_i (reg_index),
    .reg_value_i (reg_value),
    .status_i    (status),
    .last_i      (last),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  // Receiver stalls at random, at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Drive one command; optional random idle cycles come first, then wait for the transfer.
  // Valid stays up after the transfer until the next command or idle cycle replaces it.
  task automatic send_cmd(input logic [1:0] op, input logic [7:0] sa, input logic [15:0] ra,
                          input logic [15:0] va, input logic [7:0] rd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    slave_addr <= sa;
    reg_addr   <= ra;
    value      <= va;
    rx_data    <= rd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic start_request(input logic is_read, input logic [7:0] sa,
                               input logic [15:0] ra, input logic [15:0] va);
    cur_slave   = sa;
    cur_reg     = ra;
    cur_value   = va;
    cur_is_read = is_read;
    send_cmd(is_read ? OpRead : OpWrite, sa, ra, va, 8'($urandom()));
  endtask

  // Send a reply to the current request; flaw picks a defect (0 none).
  // 1 crc, 2 slave, 3 function, 4 echo/count, 5 short, 6 exception, 7 overflow.
  task automatic send_reply(input int flaw);
    logic [7:0]  buf_b[72];
    int          n;
    logic [15:0] c;
    n = 0;
    buf_b[n++] = (flaw == 2) ? cur_slave ^ 8'(1 + $urandom_range(254)) : cur_slave;
    if (flaw == 3) buf_b[n++] = 8'h10;
    else if (flaw == 6) buf_b[n++] = cur_is_read ? 8'h83 : 8'h86;
    else buf_b[n++] = cur_is_read ? FnRead : FnWrite;
    if (cur_is_read) begin
      buf_b[n++] = (flaw == 4) ? 8'(2 * cur_value + 2) : 8'(2 * cur_value);
      for (int i = 0; i < cur_value; i++) begin
        buf_b[n++] = 8'($urandom());
        buf_b[n++] = 8'($urandom());
      end
    end else begin
      buf_b[n++] = cur_reg[15:8];
      buf_b[n++] = cur_reg[7:0];
      buf_b[n++] = cur_value[15:8];
      buf_b[n++] = (flaw == 4) ? ~cur_value[7:0] : cur_value[7:0];
    end
    c = 16'hFFFF;
    for (int i = 0; i < n; i++) begin
      c = c ^ {8'h00, buf_b[i]};
      for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    if (flaw == 1) c = c ^ 16'(1 << $urandom_range(15));
    buf_b[n++] = c[7:0];
    buf_b[n++] = c[15:8];
    if (flaw == 5) n = n - 1;
    for (int i = 0; i < n; i++)
      send_cmd(OpRxByte, 8'($urandom()), 16'($urandom()), 16'($urandom()), buf_b[i]);
    if (flaw == 7)
      for (int i = n; i < 70; i++) send_cmd(OpRxByte, 0, 0, 0, 8'($urandom()));
    send_cmd(OpEnd, 8'($urandom()), 16'($urandom()), 16'($urandom()), 8'($urandom()));
  endtask

  initial begin
    int pick;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    opcode         = OpWrite;
    slave_addr     = '0;
    reg_addr       = '0;
    value          = '0;
    rx_data        = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, every command, each special case.
    send_cmd(OpEnd, 0, 0, 0, 0);                    // frame end while idle
    send_cmd(OpRxByte, 0, 0, 0, 8'hFF);             // byte while idle, dropped
    start_request(1'b0, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_reply(0);
    start_request(1'b0, 8'h00, 16'h0000, 16'h0000); // broadcast write
    send_cmd(OpEnd, 0, 0, 0, 0);
    start_request(1'b1, 8'h11, 16'h0000, 16'd0);    // read count zero
    start_request(1'b1, 8'h11, 16'h0000, 16'd17);   // read count over the limit
    start_request(1'b1, 8'h11, 16'h0000, 16'hFFFF);
    start_request(1'b1, 8'h01, 16'hA5A5, 16'd16);   // largest read
    send_reply(0);
    start_request(1'b1, 8'h02, 16'h1234, 16'd1);
    send_cmd(OpEnd, 0, 0, 0, 0);                    // no reply
    start_request(1'b0, 8'h03, 16'h0102, 16'h0304);
    start_request(1'b1, 8'h04, 16'h0001, 16'd2);    // abandons the pending write
    send_reply(7);                                  // overflow
    for (int f = 1; f <= 6; f++) begin
      start_request(f[0], 8'h05, 16'h5A5A, 16'd3);
      send_reply(f);
    end

    // Random: mostly well-formed exchanges, some noise, over four idling phases.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 27 : 47) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 27 : 47) : 0;
      for (int k = 0; k < 2; k++) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          start_request(1'($urandom_range(1)), 8'($urandom_range(1, 255)), 16'($urandom()),
                        $urandom_range(1) ? 16'($urandom_range(1, 4)) : 16'($urandom()));
          if (cur_is_read && (cur_value == 0 || cur_value > MaxReadRegsDef))
            cur_value = 16'($urandom_range(1, MaxReadRegsDef));
          if (cur_is_read) begin
            send_cmd(OpRead, cur_slave, cur_reg, cur_value, 0);
          end
          send_reply(($urandom_range(99) < 60) ? 0 : $urandom_range(1, 7));
        end else if (pick < 80) begin
          start_request(1'b0, 8'h00, 16'($urandom()), 16'($urandom()));
        end else if (pick < 90) begin
          send_cmd(2'($urandom_range(3)), 8'($urandom()), 16'($urandom()), 16'($urandom()),
                   8'($urandom()));
        end else begin
          start_request(1'b1, 8'($urandom()), 16'($urandom()), 16'($urandom()));
        end
      end
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== modbus_rtu_master_frame_engine_top.f =====
src/mrtu_pkg.sv
src/mrtu_ctrl.sv
src/mrtu_dp.sv
src/modbus_rtu_master_frame_engine_top.sv
sim/modbus_rtu_master_frame_engine_checker.sv
sim/modbus_rtu_master_frame_engine_top_tb.sv
